### design/assert_macros.svh
// Assertion macros shared by the octree insertion RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/ocin_pkg.sv
// Package for the octree insertion block: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ocin_pkg;

    localparam int NODE_POOL_SIZE = 4096;
    localparam int NODE_W         = $clog2(NODE_POOL_SIZE);
    localparam int CHILD_W        = 3;
    localparam int SLOT_W         = NODE_W + CHILD_W;
    localparam int TABLE_DEPTH    = NODE_POOL_SIZE * 8;
    localparam int NIU_W          = NODE_W + 1;
    localparam int LINK_W         = NODE_W + 1;
    localparam int COORD_W        = 32;
    localparam int HALF_W         = 31;
    localparam int EXT_W          = 34;
    localparam int DEPTH_W        = 4;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int IN_W           = 192;
    localparam int OUT_W          = 24;

    localparam logic [STATUS_W-1:0] ST_PLACED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HALF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_HALF = 2'd2;

    typedef struct packed {
        logic clr;       // write one zero entry of the sweep
        logic load;      // take the input beat
        logic advance;   // step down into the chosen child
        logic alloc;     // create the chosen child
        logic set_zero;
        logic set_full;
        logic out_load;
    } ocin_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic zero_ext;
        logic stop;
        logic link_valid;
        logic pool_full;
    } ocin_sts_t;

endpackage

`default_nettype wire

### design/ocin_dp.sv
// Datapath of the octree insertion block: object bounds, node walk,
// containment test, child link memory and result register. Uses ocin_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocin_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ocin_pkg::IN_W-1:0]      in_data,
    input  wire logic                           cfg_we,
    input  wire logic [ocin_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [ocin_pkg::HALF_W-1:0]    cfg_wdata,
    input  wire ocin_pkg::ocin_cmd_t            cmd,
    output ocin_pkg::ocin_sts_t                 sts,
    output logic [ocin_pkg::OUT_W-1:0]          out_data
);
    import ocin_pkg::*;

    logic [DEPTH_W-1:0]       max_depth_reg;
    logic [HALF_W-1:0]        min_half_reg;
    logic [HALF_W-1:0]        root_half_reg;

    logic signed [EXT_W-1:0]  omin_reg [3];
    logic signed [EXT_W-1:0]  omax_reg [3];
    logic signed [EXT_W-1:0]  nc_reg   [3];
    logic [HALF_W-1:0]        half_reg;
    logic [NODE_W-1:0]        node_reg;
    logic [DEPTH_W-1:0]       depth_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic                     zero_reg;
    logic [CHILD_W-1:0]       child_reg;
    logic [NIU_W-1:0]         niu_reg;
    logic [SLOT_W-1:0]        clr_reg;
    logic [LINK_W-1:0]        rd_reg;
    logic [OUT_W-1:0]         out_reg;

    logic [LINK_W-1:0]        link_mem [TABLE_DEPTH];

    logic [HALF_W-1:0]        ch;
    logic signed [EXT_W-1:0]  ch_s;
    logic signed [EXT_W-1:0]  two_ch;
    logic [2:0]               hi_fit;
    logic [2:0]               lo_fit;
    logic                     one_fit;
    logic                     size_stop;

    assign ch     = half_reg >> 1;
    assign ch_s   = $signed({3'b000, ch});
    assign two_ch = $signed({2'b00, ch, 1'b0});

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            hi_fit[a] = (nc_reg[a] <= omin_reg[a]) && (omax_reg[a] <= nc_reg[a] + two_ch);
            lo_fit[a] = (nc_reg[a] - two_ch <= omin_reg[a]) && (omax_reg[a] <= nc_reg[a]);
        end
    end

    assign one_fit   = &(hi_fit ^ lo_fit);
    assign size_stop = (depth_reg != '0) && (half_reg <= min_half_reg);

    assign sts.clr_last   = &clr_reg;
    assign sts.zero_ext   = zero_reg;
    assign sts.stop       = (depth_reg >= max_depth_reg) || size_stop || !one_fit;
    assign sts.link_valid = rd_reg[LINK_W-1];
    assign sts.pool_full  = niu_reg >= NIU_W'(NODE_POOL_SIZE);

    assign out_data = out_reg;

    // Control state: registers, pool count and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= DEPTH_W'(8);
            min_half_reg  <= HALF_W'(4096);
            root_half_reg <= HALF_W'(16777216);
            niu_reg       <= NIU_W'(1);
            clr_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MAX_DEPTH: max_depth_reg <= cfg_wdata[DEPTH_W-1:0];
                    CFG_MIN_HALF:  min_half_reg  <= cfg_wdata;
                    CFG_ROOT_HALF: root_half_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.alloc)
                niu_reg <= niu_reg + NIU_W'(1);
            if (cmd.clr)
                clr_reg <= clr_reg + SLOT_W'(1);
        end
    end

    // Walk state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int a = 0; a < 3; a++)
            begin
                omin_reg[a] <= $signed({{2{in_data[a*COORD_W+COORD_W-1]}},
                                        in_data[a*COORD_W +: COORD_W]})
                             - $signed({3'b000, in_data[3*COORD_W+a*HALF_W +: HALF_W]});
                omax_reg[a] <= $signed({{2{in_data[a*COORD_W+COORD_W-1]}},
                                        in_data[a*COORD_W +: COORD_W]})
                             + $signed({3'b000, in_data[3*COORD_W+a*HALF_W +: HALF_W]});
                nc_reg[a]   <= '0;
            end
            half_reg   <= root_half_reg;
            node_reg   <= '0;
            depth_reg  <= '0;
            status_reg <= ST_PLACED;
            zero_reg   <= (in_data[3*COORD_W +: 3*HALF_W] == '0);
        end
        else
        begin
            if (cmd.advance)
            begin
                for (int a = 0; a < 3; a++)
                    nc_reg[a] <= child_reg[a] ? nc_reg[a] + ch_s : nc_reg[a] - ch_s;
                half_reg  <= ch;
                depth_reg <= depth_reg + DEPTH_W'(1);
                node_reg  <= cmd.alloc ? niu_reg[NODE_W-1:0] : rd_reg[NODE_W-1:0];
            end
            if (cmd.set_zero)
                status_reg <= ST_ZERO;
            if (cmd.set_full)
                status_reg <= ST_FULL;
        end
        child_reg <= hi_fit;
        if (cmd.out_load)
            out_reg <= {6'b000000, depth_reg, status_reg, node_reg};
    end

    // Child link memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
            link_mem[clr_reg] <= '0;
        else if (cmd.alloc)
            link_mem[{node_reg, child_reg}] <= {1'b1, niu_reg[NODE_W-1:0]};
        rd_reg <= link_mem[{node_reg, hi_fit}];
    end

endmodule

`default_nettype wire

### design/ocin_ctrl.sv
// Controller of the octree insertion block: clear sweep, per-level
// test/link sequencing and the result handshake. Uses ocin_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocin_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire ocin_pkg::ocin_sts_t sts,
    output ocin_pkg::ocin_cmd_t      cmd
);
    import ocin_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_LINK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.zero_ext)
                begin
                    cmd.set_zero = 1'b1;
                    state_next   = S_DONE;
                end
                else if (sts.stop)
                    state_next = S_DONE;
                else
                    state_next = S_LINK;
            end
            S_LINK:
            begin
                if (sts.link_valid)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_EVAL;
                end
                else if (sts.pool_full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.alloc   = 1'b1;
                    cmd.advance = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/octree_insert_node_assign.sv
// Top level of the octree insertion block: streams, configuration port,
// controller and datapath. Uses ocin_pkg, ocin_ctrl, ocin_dp, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Walks one object box down an octree rooted at the origin and returns the
// node that receives it. After reset the child link memory is swept clear,
// entry by entry, with s_tready low; configuration writes are taken
// throughout. Each item is loaded in S_IDLE; each level descended takes an
// S_EVAL state (containment test plus link memory read) and an S_LINK state
// (link follow or child allocation). The walk ends in S_EVAL on a zero
// extent, a limit or a failed fit, or in S_LINK when the node pool is full;
// S_DONE then loads the output register. One item is in flight at a time; a
// finished result may wait in the output register while the next beat is taken.
module octree_insert_node_assign (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // obj_center_x, obj_center_y, obj_center_z, obj_half_x, obj_half_y, obj_half_z
    input  wire logic [ocin_pkg::IN_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // node_index, status, node_depth
    output logic [ocin_pkg::OUT_W-1:0]          m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [ocin_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [ocin_pkg::HALF_W-1:0]    cfg_wdata
);
    import ocin_pkg::*;

    ocin_cmd_t cmd;
    ocin_sts_t sts;

    ocin_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ocin_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata)
    );

    `ASSERT_ALWAYS(a_status_code, !m_tvalid || (m_tdata[13:12] != 2'd3), "bad status code")
    `ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second beat taken mid-walk")
    `ASSERT_ALWAYS(a_alloc_room, !cmd.alloc || !sts.pool_full, "allocation with pool full")
    `ASSERT_ALWAYS(a_clear_quiet, !cmd.clr || !(s_tvalid && s_tready), "beat taken during clear")

endmodule

`default_nettype wire

### verif/octree_box_checker.sv
// Watches the object, result and register ports of the octree insertion block,
// predicts the receiving node of every object box and compares field by field.
// Needs ocin_pkg for sizes and status codes.
`timescale 1ns / 1ps

module octree_box_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ocin_pkg::IN_W-1:0]      s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ocin_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_we,
    input  logic [ocin_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [ocin_pkg::HALF_W-1:0]    cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             boxes_seen,
    output int                             full_seen,
    output int                             zero_seen
);
    import ocin_pkg::*;

    // first field on top: node in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [3:0]  depth;
        logic [1:0]  status;
        logic [11:0] node;
    } placement_t;

    localparam int PLAN_DEPTH = 64;

    // valid bit on top of the child node index
    logic [NODE_W:0]  link_tab [TABLE_DEPTH];
    int unsigned      nodes_used;
    logic [3:0]       depth_limit;
    longint           min_half;
    longint           root_half;
    placement_t       plan_q [PLAN_DEPTH];
    int               wr_cnt;
    int               rd_cnt;

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            link_tab[i] = '0;
        nodes_used  = 1;
        depth_limit = 4'd8;
        min_half    = 4096;
        root_half   = 16777216;
        fail_count  = 0;
        boxes_seen  = 0;
        full_seen   = 0;
        zero_seen   = 0;
        wr_cnt      = 0;
        rd_cnt      = 0;
    end

    assign pending = wr_cnt - rd_cnt;

    function automatic placement_t place_box(logic [IN_W-1:0] d);
        longint     oc [3];
        longint     oh [3];
        longint     nc [3];
        longint     half;
        longint     ch;
        longint     cc;
        int         fit_n;
        int         fit_c;
        int         slot;
        bit         ok;
        placement_t r;
        r = '0;
        for (int a = 0; a < 3; a++)
        begin
            oc[a] = longint'($signed(d[a*32 +: 32]));
            oh[a] = longint'(d[96 + a*31 +: 31]);
            nc[a] = 0;
        end
        if (oh[0] == 0 && oh[1] == 0 && oh[2] == 0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        r.status = ST_PLACED;
        half = root_half;
        while (r.depth < depth_limit)
        begin
            ch = half >>> 1;
            if (r.node != 0 && half <= min_half)
                break;
            fit_n = 0;
            fit_c = 0;
            for (int c = 0; c < 8; c++)
            begin
                ok = 1;
                for (int a = 0; a < 3; a++)
                begin
                    cc = c[a] ? nc[a] + ch : nc[a] - ch;
                    if (!((cc - ch) <= (oc[a] - oh[a]) && (oc[a] + oh[a]) <= (cc + ch)))
                        ok = 0;
                end
                if (ok)
                begin
                    fit_n++;
                    fit_c = c;
                end
            end
            if (fit_n != 1)
                break;
            slot = int'(r.node) * 8 + fit_c;
            if (!link_tab[slot][NODE_W])
            begin
                if (nodes_used >= NODE_POOL_SIZE)
                begin
                    r.status = ST_FULL;
                    break;
                end
                link_tab[slot] = {1'b1, nodes_used[NODE_W-1:0]};
                nodes_used++;
            end
            r.node = link_tab[slot][NODE_W-1:0];
            for (int a = 0; a < 3; a++)
                nc[a] = fit_c[a] ? nc[a] + ch : nc[a] - ch;
            half = ch;
            r.depth++;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        placement_t want;
        placement_t got;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_MAX_DEPTH)
                    depth_limit = cfg_wdata[3:0];
                else if (cfg_addr == CFG_MIN_HALF)
                    min_half = longint'(cfg_wdata);
                else if (cfg_addr == CFG_ROOT_HALF)
                    root_half = longint'(cfg_wdata);
            end
            if (s_tvalid && s_tready)
            begin
                want = place_box(s_tdata);
                plan_q[wr_cnt % PLAN_DEPTH] = want;
                wr_cnt++;
                boxes_seen++;
                if (want.status == ST_FULL)
                    full_seen++;
                if (want.status == ST_ZERO)
                    zero_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[17:0];
                if (wr_cnt == rd_cnt)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %h", got);
                end
                else
                begin
                    want = plan_q[rd_cnt % PLAN_DEPTH];
                    rd_cnt++;
                    if (got.node != want.node || got.status != want.status
                        || got.depth != want.depth || m_tdata[OUT_W-1:18] != '0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: node %0d/%0d status %0d/%0d depth %0d/%0d",
                                     want.node, got.node, want.status, got.status,
                                     want.depth, got.depth);
                    end
                end
            end
        end
    end

endmodule

### verif/tb_octree_insert_node_assign.sv
// Top of the octree insertion testbench: clock, reset, register writes,
// object box and result stimulus, verdict. Uses ocin_pkg and octree_box_checker.
`timescale 1ns / 1ps

module tb_octree_insert_node_assign;
    import ocin_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [HALF_W-1:0]    cfg_wdata;
    int                   fail_count;
    int                   pending;
    int                   boxes_seen;
    int                   full_seen;
    int                   zero_seen;
    int                   reg_writes;
    bit                   calm;
    bit                   hold_req;
    bit                   hold_done;
    int                   hold_left;

    octree_insert_node_assign dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    octree_box_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .boxes_seen (boxes_seen),
        .full_seen  (full_seen),
        .zero_seen  (zero_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("timeout");
        $display("tb_octree_insert_node_assign failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 13);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        reg_writes++;
        @(posedge clk);
    endtask

    // drop the last beat, then wait until every result has come back
    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic end_regs;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
        if (!calm && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, hz, hy, hx, cz, cy, cx};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // small box at a random spot inside a cube of half-extent 2^span
    task automatic send_nested(int span);
        int          k;
        logic [31:0] c [3];
        k = $urandom_range(0, span);
        for (int a = 0; a < 3; a++)
            c[a] = $signed($urandom) >>> (31 - span);
        send_box(c[0], c[1], c[2], 31'($urandom_range(0, 1 << k)),
                 31'($urandom_range(0, 1 << k)), 31'($urandom_range(1, 1 << k)));
    endtask

    task automatic send_noise;
        send_box($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                 31'($urandom));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        reg_writes = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero extent, whole-space boxes, extremes, a few nested boxes
        send_box(32'd0, 32'd0, 32'd0, 31'd0, 31'd0, 31'd0);
        send_box(32'h8000_0000, 32'h7fff_ffff, 32'd5, 31'd0, 31'd0, 31'd0);
        send_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff,
                 31'h7fff_ffff, 31'h7fff_ffff);
        send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd1, 31'd1, 31'd1);
        send_box(32'd0, 32'd0, 32'd0, 31'd1, 31'd1, 31'd1);
        send_box(32'd100, 32'd100, 32'd100, 31'd1, 31'd0, 31'd0);
        send_box(32'd8388608, 32'd8388608, 32'd8388608, 31'd8388608, 31'd8388608,
                 31'd8388608);
        send_box(-32'sd8388608, 32'd8388608, -32'sd8388608, 31'd4096, 31'd4096, 31'd4096);
        for (int i = 0; i < 6; i++)
            send_nested(24);
        settle();

        // depth zero (upper bits dropped), out-of-range index ignored
        write_reg(CFG_MAX_DEPTH, 31'h7fff_fff0);
        write_reg(2'd3, 31'd5);
        end_regs();
        send_box(32'd100, 32'd100, 32'd100, 31'd1, 31'd1, 31'd1);
        send_nested(24);
        settle();

        // point-sized children under a zero root
        write_reg(CFG_MAX_DEPTH, 31'd15);
        write_reg(CFG_ROOT_HALF, 31'd0);
        end_regs();
        send_box(32'd0, 32'd0, 32'd0, 31'd1, 31'd1, 31'd1);
        send_box(32'd0, 32'd0, 32'd0, 31'd0, 31'd0, 31'd2);
        settle();

        // widest root, no size floor
        write_reg(CFG_ROOT_HALF, 31'd1073741824);
        write_reg(CFG_MIN_HALF, 31'd0);
        end_regs();
        calm <= 1'b1;
        for (int i = 0; i < 60; i++)
            send_nested(30);
        calm <= 1'b0;
        for (int i = 0; i < 90; i++)
            if ($urandom_range(9) == 0)
                send_noise();
            else
                send_nested(30);
        settle();

        // largest floor: stop at the first level
        write_reg(CFG_MIN_HALF, 31'd1073741824);
        end_regs();
        for (int i = 0; i < 20; i++)
            send_nested(30);
        settle();

        // deep small boxes until the node pool runs dry
        write_reg(CFG_MIN_HALF, 31'd0);
        write_reg(CFG_ROOT_HALF, 31'd16777216);
        end_regs();
        hold_req <= 1'b1;
        for (int i = 0; i < 260; i++)
            if ($urandom_range(9) == 0)
                send_noise();
            else
                send_nested(24);

        settle();
        repeat (60) @(posedge clk);
        $display("%0d boxes over %0d register writes: %0d zero-extent, %0d pool-full",
                 boxes_seen, reg_writes, zero_seen, full_seen);
        if (fail_count == 0)
            $display("tb_octree_insert_node_assign passed");
        else
            $display("tb_octree_insert_node_assign failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ocin_pkg.sv
design/ocin_dp.sv
design/ocin_ctrl.sv
design/octree_insert_node_assign.sv
verif/octree_box_checker.sv
verif/tb_octree_insert_node_assign.sv
